FILE: sv/pps_pkg.sv
// pps_pkg: shared types and constants for the perspective projection block
// no dependencies
package pps_pkg;

  localparam int unsigned CoordW = 32;
  localparam int unsigned ProdW  = 64;
  localparam int unsigned QuotW  = 41;
  localparam int unsigned IdxW   = 2;

  localparam logic [IdxW-1:0] REG_FOCAL  = 2'd0;
  localparam logic [IdxW-1:0] REG_WIDTH  = 2'd1;
  localparam logic [IdxW-1:0] REG_HEIGHT = 2'd2;

  localparam logic signed [31:0] SMAX = 32'sh7fffffff;
  localparam logic signed [31:0] SMIN = 32'sh80000000;

  typedef struct packed {
    logic [31:0] view_x;
    logic [31:0] view_y;
    logic [31:0] view_z;
  } in_item_t;

  typedef struct packed {
    logic [31:0] screen_x;
    logic [31:0] screen_y;
    logic [31:0] depth;
    logic        zero_depth;
    logic        saturated;
  } out_item_t;

  typedef struct packed {
    logic [IdxW-1:0] index;
    logic [31:0]     data;
  } cfg_item_t;

endpackage

FILE: sv/pps_if.sv
// pps_if: valid/ready channel interface carrying one payload type
// no package dependencies; the payload type is a parameter
interface pps_if #(
  parameter type payload_t = logic [31:0]
) (
  input logic clk
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (input clk, output valid, output data, input ready);
  modport sink   (input clk, input valid, input data, output ready);
endinterface

FILE: sv/pps_div.sv
// pps_div: pipelined unsigned restoring divider, one quotient bit per stage
// no package dependencies; stage enable shared with the main pipeline
module pps_div #(
  parameter int unsigned NW = 64,
  parameter int unsigned DW = 32,
  parameter int unsigned TW = 8
) (
  input  logic          clk,
  input  logic          en,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  input  logic [TW-1:0] tag,
  output logic [NW-1:0] quo,
  output logic [TW-1:0] tag_out
);
  // stage k decides quotient bit NW-1-k
  logic [NW-1:0] n_r   [NW+1];
  logic [DW:0]   rem_r [NW+1];
  logic [DW-1:0] d_r   [NW+1];
  logic [TW-1:0] t_r   [NW+1];

  always_comb begin
    n_r[0]   = num;
    rem_r[0] = '0;
    d_r[0]   = den;
    t_r[0]   = tag;
  end

  for (genvar k = 0; k < NW; k++) begin : g_st
    logic [DW+1:0] trial;
    logic [DW:0]   rem_nxt;
    logic [NW-1:0] n_nxt;
    always_comb begin
      trial   = {rem_r[k], n_r[k][NW-1]};
      n_nxt   = {n_r[k][NW-2:0], 1'b0};
      rem_nxt = trial[DW:0];
      if (trial >= {2'b00, d_r[k]}) begin
        rem_nxt  = (DW+1)'(trial - {2'b00, d_r[k]});
        n_nxt[0] = 1'b1;
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        n_r[k+1]   <= n_nxt;
        rem_r[k+1] <= rem_nxt;
        d_r[k+1]   <= d_r[k];
        t_r[k+1]   <= t_r[k];
      end
    end
  end

  assign quo     = n_r[NW];
  assign tag_out = t_r[NW];
endmodule

FILE: sv/perspective_project_to_screen_top.sv
// perspective_project_to_screen_top: point projection pipeline, config regs
// depends on pps_pkg, pps_if, pps_div
//
// channel | dir | payload
// in_     | in  | view_x, view_y, view_z (signed fixed point)
// out_    | out | screen_x, screen_y, depth, zero_depth, saturated
// cfg_    | in  | index (focal_scale=0, width=1, height=2), data
//
// one point per cycle sustained while the output is not blocked; registers in order:
// multiply, 64 divider stages, ndc clamp and offset, size multiply, halve and
// clamp into the output register.
// rst_n clears all valid bits and loads register defaults.
// a stall freezes every stage; the input is ready whenever the output is not blocked.
module perspective_project_to_screen_top #(
  parameter int unsigned FRAC_BITS = 16
) (
  input logic      clk,
  input logic      rst_n,
  pps_if.sink      in_ch,
  pps_if.source    out_ch,
  pps_if.sink      cfg_ch
);
  localparam int unsigned NW  = pps_pkg::ProdW;
  localparam int unsigned LAT = NW + 4;
  localparam logic [40:0] NLIM = 41'd1 << 40;

  logic [31:0] focal_r;
  logic [15:0] width_r, height_r;

  assign cfg_ch.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      focal_r  <= 32'd1 << FRAC_BITS;
      width_r  <= 16'd640;
      height_r <= 16'd480;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.data.index)
        pps_pkg::REG_FOCAL:  focal_r  <= cfg_ch.data.data;
        pps_pkg::REG_WIDTH:  width_r  <= cfg_ch.data.data[15:0];
        pps_pkg::REG_HEIGHT: height_r <= cfg_ch.data.data[15:0];
        default: ;
      endcase
    end
  end

  // global stall: the whole pipe advances unless the output holds a stuck item
  logic en;
  logic [LAT-1:0] v_r;
  assign en = !out_ch.valid || out_ch.ready;
  assign in_ch.ready = en;
  always_ff @(posedge clk) begin
    if (!rst_n) v_r <= '0;
    else if (en) v_r <= {v_r[LAT-2:0], in_ch.valid};
  end

  // stage 1: magnitudes and products
  pps_pkg::in_item_t it;
  assign it = in_ch.data;
  logic signed [32:0] dep;
  logic [32:0] dmag;
  logic [31:0] xm, ym;
  logic nx, ny;
  always_comb begin
    dep  = -$signed({it.view_z[31], it.view_z});
    dmag = dep[32] ? 33'(-dep) : 33'(dep);
    xm   = it.view_x[31] ? 32'(-it.view_x) : it.view_x;
    ym   = it.view_y[31] ? 32'(-it.view_y) : it.view_y;
    nx   = it.view_x[31] ^ dep[32];
    ny   = it.view_y[31] ^ dep[32];
  end

  logic [63:0] px_r, py_r;
  logic [32:0] dm_r;
  logic [33:0] meta1_r; // nx, ny, zero, then 31 unused zero bits
  logic [32:0] dep_r;
  always_ff @(posedge clk) begin
    if (en) begin
      px_r    <= 64'(xm) * 64'(focal_r);
      py_r    <= 64'(ym) * 64'(focal_r);
      dm_r    <= (it.view_z == '0) ? 33'd1 : dmag;
      meta1_r <= {nx, ny, (it.view_z == '0), 31'd0};
      dep_r   <= dep;
    end
  end

  localparam int unsigned TW = 36;
  logic [63:0] qx, qy;
  logic [TW-1:0] tx, ty;
  pps_div #(.NW(NW), .DW(33), .TW(TW)) u_divx (
    .clk, .en, .num(px_r), .den(dm_r),
    .tag({meta1_r[33:31], dep_r}), .quo(qx), .tag_out(tx));
  pps_div #(.NW(NW), .DW(33), .TW(TW)) u_divy (
    .clk, .en, .num(py_r), .den(dm_r), .tag('0), .quo(qy), .tag_out(ty));

  // ndc clamp and offset
  logic signed [42:0] ax_r, ay_r;
  logic [35:0] t2_r;
  logic signed [42:0] onev;
  logic [40:0] cqx, cqy;
  assign onev = 43'sd1 <<< FRAC_BITS;
  always_comb begin
    cqx = (qx > 64'(NLIM)) ? NLIM : qx[40:0];
    cqy = (qy > 64'(NLIM)) ? NLIM : qy[40:0];
  end
  always_ff @(posedge clk) begin
    if (en) begin
      ax_r <= (tx[35] ? -$signed({2'b0, cqx}) : $signed({2'b0, cqx})) + onev;
      ay_r <= onev - (tx[34] ? -$signed({2'b0, cqy}) : $signed({2'b0, cqy}));
      t2_r <= tx;
    end
  end

  // scale by size
  logic signed [59:0] mx_r, my_r;
  logic [35:0] t3_r;
  always_ff @(posedge clk) begin
    if (en) begin
      mx_r <= 60'(ax_r) * 60'($signed({1'b0, width_r}));
      my_r <= 60'(ay_r) * 60'($signed({1'b0, height_r}));
      t3_r <= t2_r;
    end
  end

  // halve toward zero and clamp
  logic signed [59:0] hx, hy;
  logic signed [32:0] dd;
  logic sx_hi, sx_lo, sy_hi, sy_lo, d_hi, zr;
  pps_pkg::out_item_t res;
  always_comb begin
    hx = (mx_r + $signed({59'd0, mx_r[59]})) >>> 1;
    hy = (my_r + $signed({59'd0, my_r[59]})) >>> 1;
    dd = $signed(t3_r[32:0]);
    zr = t3_r[33];
    sx_hi = hx > 60'(pps_pkg::SMAX);
    sx_lo = hx < 60'(pps_pkg::SMIN);
    sy_hi = hy > 60'(pps_pkg::SMAX);
    sy_lo = hy < 60'(pps_pkg::SMIN);
    d_hi  = dd > 33'(pps_pkg::SMAX);
    res.screen_x = sx_hi ? pps_pkg::SMAX : sx_lo ? pps_pkg::SMIN : hx[31:0];
    res.screen_y = sy_hi ? pps_pkg::SMAX : sy_lo ? pps_pkg::SMIN : hy[31:0];
    res.depth    = d_hi ? pps_pkg::SMAX : dd[31:0];
    res.zero_depth = zr;
    res.saturated  = sx_hi | sx_lo | sy_hi | sy_lo | d_hi;
    if (zr) begin
      res.screen_x  = '0;
      res.screen_y  = '0;
      res.depth     = '0;
      res.saturated = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) out_ch.data <= res;
  end
  assign out_ch.valid = v_r[LAT-1];
  logic unused;
  assign unused = ^ty ^ ^meta1_r[30:0];
endmodule
